>>> hdl/rva_pkg.sv
package rva_pkg;

  localparam int unsigned XLEN = 32;
  localparam int unsigned CMD_W = 10;
  localparam int unsigned REG_W = 5;
  localparam int unsigned SHAMT_W = 5;

  localparam logic [CMD_W-1:0] CMD_ADD    = 10'h000;
  localparam logic [CMD_W-1:0] CMD_SUB    = 10'h100;
  localparam logic [CMD_W-1:0] CMD_SLL    = 10'h001;
  localparam logic [CMD_W-1:0] CMD_SLT    = 10'h002;
  localparam logic [CMD_W-1:0] CMD_SLTU   = 10'h003;
  localparam logic [CMD_W-1:0] CMD_XOR    = 10'h004;
  localparam logic [CMD_W-1:0] CMD_SRL    = 10'h005;
  localparam logic [CMD_W-1:0] CMD_SRA    = 10'h105;
  localparam logic [CMD_W-1:0] CMD_OR     = 10'h006;
  localparam logic [CMD_W-1:0] CMD_AND    = 10'h007;
  localparam logic [CMD_W-1:0] CMD_MUL    = 10'h008;
  localparam logic [CMD_W-1:0] CMD_MULH   = 10'h009;
  localparam logic [CMD_W-1:0] CMD_MULHSU = 10'h00A;
  localparam logic [CMD_W-1:0] CMD_MULHU  = 10'h00B;
  localparam logic [CMD_W-1:0] CMD_DIV    = 10'h00C;
  localparam logic [CMD_W-1:0] CMD_DIVU   = 10'h00D;
  localparam logic [CMD_W-1:0] CMD_REM    = 10'h00E;
  localparam logic [CMD_W-1:0] CMD_REMU   = 10'h00F;

  typedef struct packed {
    logic             valid;
    logic             illegal;
    logic [REG_W-1:0] rd;
    logic [XLEN-1:0]  res;
    logic [XLEN-1:0]  npc;
    logic             is_div;
    logic             want_rem;
    logic             neg_q;
    logic             neg_r;
    logic             bzero;
    logic [XLEN-1:0]  a_orig;
    logic [XLEN-1:0]  rem;
    logic [XLEN-1:0]  qd;
    logic [XLEN-1:0]  dvs;
  } word_t;

endpackage

>>> hdl/rv32im_register_alu_core.sv
// RV32IM register-register execute unit.
// Slave channel s_axis_*: one instruction word per handshake; tuser carries
// the funct7:funct3 code, tdata carries rd, rs1 value, rs2 value and pc.
// Master channel m_axis_*: one result word per instruction, in order;
// tuser flags an unlisted code (write value zero, pc held), tdata carries rd,
// write value and next pc.
// The path is one decode/multiply stage, a chain of 32 divider
// cells (one quotient bit per cell, every instruction walks the chain),
// and the output register. Throughput is one word per cycle unless the receiver stalls.
// The whole chain advances whenever the output register is empty or being
// taken; when the receiver stalls with a result held, s_axis_tready drops
// and every stage holds. Reset empties the chain and the output register.
module rv32im_register_alu_core #(
  parameter int unsigned INSTR_STEP = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,  // dest_reg, operand_a, operand_b, pc_value, pad
  input  logic [9:0]   s_axis_tuser,  // cmd
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata,  // write_reg, write_value, next_pc, pad
  output logic         m_axis_tuser   // illegal
);

  localparam int unsigned NCELL = rva_pkg::XLEN;
  localparam int unsigned X = rva_pkg::XLEN;
  localparam int unsigned R = rva_pkg::REG_W;

  logic en;
  rva_pkg::word_t chain [NCELL+1];
  logic [X-1:0] quo, rmd, val_d, val_q, npc_q;
  logic [R-1:0] rd_q;
  logic out_valid_q, ill_q;

  assign en = !out_valid_q || m_axis_tready;

  rva_front #(.INSTR_STEP(INSTR_STEP)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .cmd_i   (s_axis_tuser),
    .rd_i    (s_axis_tdata[R-1:0]),
    .a_i     (s_axis_tdata[R+X-1:R]),
    .b_i     (s_axis_tdata[R+2*X-1:R+X]),
    .pc_i    (s_axis_tdata[R+3*X-1:R+2*X]),
    .word_o  (chain[0])
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    rva_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .word_i (chain[i]),
      .word_o (chain[i+1])
    );
  end

  always_comb begin
    quo = chain[NCELL].neg_q ? ('0 - chain[NCELL].qd) : chain[NCELL].qd;
    rmd = chain[NCELL].neg_r ? ('0 - chain[NCELL].rem) : chain[NCELL].rem;
    val_d = chain[NCELL].res;
    if (chain[NCELL].is_div) begin
      if (chain[NCELL].bzero) begin
        val_d = chain[NCELL].want_rem ? chain[NCELL].a_orig : '1;
      end else begin
        val_d = chain[NCELL].want_rem ? rmd : quo;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= chain[NCELL].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      val_q <= val_d;
      npc_q <= chain[NCELL].npc;
      rd_q <= chain[NCELL].rd;
      ill_q <= chain[NCELL].illegal;
    end
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser = ill_q;
  assign m_axis_tdata = {3'b000, npc_q, val_q, rd_q};

  a_ill_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[R+X-1:R] == '0)
    else $error("illegal word with nonzero write value");

  a_last_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && chain[NCELL].valid |=> m_axis_tvalid)
    else $error("word lost at end of chain");

  a_ill_not_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[0].valid && chain[0].illegal |-> !chain[0].is_div)
    else $error("illegal word routed to divider");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(chain[NCELL].qd) && $stable(chain[NCELL].valid))
    else $error("chain moved while stalled");

endmodule

>>> hdl/rva_front.sv
module rva_front #(
  parameter int unsigned INSTR_STEP = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [rva_pkg::CMD_W-1:0]   cmd_i,
  input  logic [rva_pkg::REG_W-1:0]   rd_i,
  input  logic [rva_pkg::XLEN-1:0]    a_i,
  input  logic [rva_pkg::XLEN-1:0]    b_i,
  input  logic [rva_pkg::XLEN-1:0]    pc_i,
  output rva_pkg::word_t              word_o
);

  rva_pkg::word_t word_d, word_q;
  logic [rva_pkg::SHAMT_W-1:0] sh;
  logic sgn_a, sgn_b, div_sgn;
  logic signed [rva_pkg::XLEN:0] ma, mb;
  logic signed [2*rva_pkg::XLEN+1:0] prod;

  assign sh = b_i[rva_pkg::SHAMT_W-1:0];
  assign sgn_a = (cmd_i == rva_pkg::CMD_MULH) || (cmd_i == rva_pkg::CMD_MULHSU);
  assign sgn_b = (cmd_i == rva_pkg::CMD_MULH);
  assign ma = $signed({sgn_a & a_i[rva_pkg::XLEN-1], a_i});
  assign mb = $signed({sgn_b & b_i[rva_pkg::XLEN-1], b_i});
  assign prod = ma * mb;

  always_comb begin
    div_sgn = 1'b0;
    word_d = '0;
    word_d.valid = valid_i;
    word_d.rd = rd_i;
    word_d.a_orig = a_i;
    word_d.dvs = b_i;
    word_d.qd = a_i;
    word_d.bzero = (b_i == '0);
    word_d.npc = pc_i + rva_pkg::XLEN'(INSTR_STEP);
    unique case (cmd_i)
      rva_pkg::CMD_ADD:  word_d.res = a_i + b_i;
      rva_pkg::CMD_SUB:  word_d.res = a_i - b_i;
      rva_pkg::CMD_SLL:  word_d.res = a_i << sh;
      rva_pkg::CMD_SLT:  word_d.res = rva_pkg::XLEN'($signed(a_i) < $signed(b_i));
      rva_pkg::CMD_SLTU: word_d.res = rva_pkg::XLEN'(a_i < b_i);
      rva_pkg::CMD_XOR:  word_d.res = a_i ^ b_i;
      rva_pkg::CMD_SRL:  word_d.res = a_i >> sh;
      rva_pkg::CMD_SRA:  word_d.res = rva_pkg::XLEN'($signed(a_i) >>> sh);
      rva_pkg::CMD_OR:   word_d.res = a_i | b_i;
      rva_pkg::CMD_AND:  word_d.res = a_i & b_i;
      rva_pkg::CMD_MUL:  word_d.res = prod[rva_pkg::XLEN-1:0];
      rva_pkg::CMD_MULH: begin
        word_d.res = prod[2*rva_pkg::XLEN-1:rva_pkg::XLEN];
      end
      rva_pkg::CMD_MULHSU: begin
        word_d.res = prod[2*rva_pkg::XLEN-1:rva_pkg::XLEN];
      end
      rva_pkg::CMD_MULHU: word_d.res = prod[2*rva_pkg::XLEN-1:rva_pkg::XLEN];
      rva_pkg::CMD_DIV: begin
        word_d.is_div = 1'b1;
        div_sgn = 1'b1;
      end
      rva_pkg::CMD_DIVU: word_d.is_div = 1'b1;
      rva_pkg::CMD_REM: begin
        word_d.is_div = 1'b1;
        word_d.want_rem = 1'b1;
        div_sgn = 1'b1;
      end
      rva_pkg::CMD_REMU: begin
        word_d.is_div = 1'b1;
        word_d.want_rem = 1'b1;
      end
      default: begin
        word_d.illegal = 1'b1;
        word_d.npc = pc_i;
      end
    endcase
    if (div_sgn) begin
      word_d.neg_q = a_i[rva_pkg::XLEN-1] ^ b_i[rva_pkg::XLEN-1];
      word_d.neg_r = a_i[rva_pkg::XLEN-1];
      if (a_i[rva_pkg::XLEN-1]) word_d.qd = '0 - a_i;
      if (b_i[rva_pkg::XLEN-1]) word_d.dvs = '0 - b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else if (en_i) begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule

>>> hdl/rva_div_cell.sv
module rva_div_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  rva_pkg::word_t word_i,
  output rva_pkg::word_t word_o
);

  rva_pkg::word_t word_d, word_q;
  logic [rva_pkg::XLEN:0] trial, diff;
  logic qbit;

  // one restoring step: shift in next dividend bit, subtract if it fits
  assign trial = {word_i.rem, word_i.qd[rva_pkg::XLEN-1]};
  assign diff = trial - {1'b0, word_i.dvs};
  assign qbit = !diff[rva_pkg::XLEN];

  always_comb begin
    word_d = word_i;
    word_d.rem = qbit ? diff[rva_pkg::XLEN-1:0] : trial[rva_pkg::XLEN-1:0];
    word_d.qd = {word_i.qd[rva_pkg::XLEN-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else if (en_i) begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule

>>> tb/sv/rv32im_register_alu_core_tb.sv
`timescale 1ns / 100ps

module rv32im_register_alu_core_tb;

  localparam int unsigned STEP = 4;
  localparam int unsigned LIMIT = 400000;

  typedef struct packed {
    logic            illegal;
    logic [4:0]      rd;
    logic [31:0]     value;
    logic [31:0]     npc;
  } alu_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic [9:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [71:0]  m_axis_tdata;
  logic         m_axis_tuser;

  alu_result_t pending_results[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          hold_off = 1'b0;

  rv32im_register_alu_core #(.INSTR_STEP(STEP)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [31:0] abs32(logic [31:0] v);
    return v[31] ? -v : v;
  endfunction

  function automatic alu_result_t execute_instr(logic [9:0] cmd, logic [4:0] rd,
                                                logic [31:0] a, logic [31:0] b,
                                                logic [31:0] pc);
    alu_result_t r;
    logic [63:0] p;
    logic [31:0] q;
    logic [4:0]  sh;
    sh = b[4:0];
    r.illegal = 1'b0;
    r.rd = rd;
    r.value = '0;
    r.npc = pc + STEP;
    case (cmd)
      rva_pkg::CMD_ADD:  r.value = a + b;
      rva_pkg::CMD_SUB:  r.value = a - b;
      rva_pkg::CMD_SLL:  r.value = a << sh;
      rva_pkg::CMD_SLT:  r.value = {31'b0, $signed(a) < $signed(b)};
      rva_pkg::CMD_SLTU: r.value = {31'b0, a < b};
      rva_pkg::CMD_XOR:  r.value = a ^ b;
      rva_pkg::CMD_SRL:  r.value = a >> sh;
      rva_pkg::CMD_SRA:  r.value = $unsigned($signed(a) >>> sh);
      rva_pkg::CMD_OR:   r.value = a | b;
      rva_pkg::CMD_AND:  r.value = a & b;
      rva_pkg::CMD_MUL:  r.value = a * b;
      rva_pkg::CMD_MULH: begin
        p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
        r.value = p[63:32];
      end
      rva_pkg::CMD_MULHSU: begin
        p = {{32{a[31]}}, a} * {32'b0, b};
        r.value = p[63:32];
      end
      rva_pkg::CMD_MULHU: begin
        p = {32'b0, a} * {32'b0, b};
        r.value = p[63:32];
      end
      rva_pkg::CMD_DIV: begin
        if (b == 0) r.value = '1;
        else if (a == 32'h8000_0000 && b == '1) r.value = a;
        else begin
          q = abs32(a) / abs32(b);
          r.value = (a[31] ^ b[31]) ? -q : q;
        end
      end
      rva_pkg::CMD_DIVU: r.value = (b == 0) ? '1 : a / b;
      rva_pkg::CMD_REM: begin
        if (b == 0) r.value = a;
        else if (a == 32'h8000_0000 && b == '1) r.value = '0;
        else begin
          q = abs32(a) % abs32(b);
          r.value = a[31] ? -q : q;
        end
      end
      rva_pkg::CMD_REMU: r.value = (b == 0) ? a : a % b;
      default: begin
        r.illegal = 1'b1;
        r.npc = pc;
      end
    endcase
    return r;
  endfunction

  task automatic send_instr(logic [9:0] cmd, logic [4:0] rd, logic [31:0] a,
                            logic [31:0] b, logic [31:0] pc, bit gaps = 1'b1);
    int unsigned gap;
    gap = gaps ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {3'b0, pc, b, a, rd};
    pending_results.push_back(execute_instr(cmd, rd, a, b, pc));
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic idle_sender();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      alu_result_t got, want;
      got.illegal = m_axis_tuser;
      got.rd = m_axis_tdata[4:0];
      got.value = m_axis_tdata[36:5];
      got.npc = m_axis_tdata[68:37];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want || m_axis_tdata[71:69] !== 3'b0) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp ill=%b rd=%0d val=%h npc=%h,",
                      " got ill=%b rd=%0d val=%h npc=%h"},
                     want.illegal, want.rd, want.value, want.npc,
                     got.illegal, got.rd, got.value, got.npc);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("rv32im_register_alu_core verification failed");
      $finish;
    end
  end

  // receiver stall pattern: a random wait before each ready cycle, or a long hold
  initial begin
    int unsigned w;
    forever begin
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (120) @(posedge clk_i);
        hold_off = 1'b0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (w != 0) begin
        m_axis_tready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  task automatic test_directed();
    logic [9:0] ops[18];
    ops = '{rva_pkg::CMD_ADD, rva_pkg::CMD_SUB, rva_pkg::CMD_SLL, rva_pkg::CMD_SLT,
            rva_pkg::CMD_SLTU, rva_pkg::CMD_XOR, rva_pkg::CMD_SRL, rva_pkg::CMD_SRA,
            rva_pkg::CMD_OR, rva_pkg::CMD_AND, rva_pkg::CMD_MUL, rva_pkg::CMD_MULH,
            rva_pkg::CMD_MULHSU, rva_pkg::CMD_MULHU, rva_pkg::CMD_DIV,
            rva_pkg::CMD_DIVU, rva_pkg::CMD_REM, rva_pkg::CMD_REMU};
    foreach (ops[i]) send_instr(ops[i], 5'(i), 32'h8000_0001, 32'hFFFF_FFE3, 32'hFFFF_FFFC);
    send_instr(rva_pkg::CMD_DIV, 5'd31, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0);
    send_instr(rva_pkg::CMD_REM, 5'd0, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0);
    send_instr(rva_pkg::CMD_DIV, 5'd1, 32'hFFFF_FFF9, 32'h0, 32'h100);
    send_instr(rva_pkg::CMD_REMU, 5'd2, 32'h1234_5678, 32'h0, 32'h104);
    send_instr(rva_pkg::CMD_REM, 5'd3, 32'hFFFF_FFF9, 32'h2, 32'h108);
    send_instr(10'h3FF, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_instr(10'h010, 5'd4, 32'h1, 32'h1, 32'h10);
  endtask

  task automatic test_random(int unsigned n);
    logic [9:0]  cmd;
    logic [31:0] a, b;
    int unsigned k;
    repeat (n) begin
      k = $urandom_range(0, 19);
      cmd = (k < 10) ? {3'b0, 7'($urandom_range(0, 15))} :
            (k < 12) ? rva_pkg::CMD_SUB : (k < 14) ? rva_pkg::CMD_SRA :
            (k < 15) ? 10'($urandom) : rva_pkg::CMD_DIV + 10'($urandom_range(0, 3));
      a = $urandom;
      b = $urandom;
      case ($urandom_range(0, 7))
        0: b = 0;
        1: b = 32'($urandom_range(0, 9)) - 32'd5;
        2: begin a = 32'h8000_0000; b = '1; end
        3: a = 32'($urandom_range(0, 3)) - 32'd2;
        default: ;
      endcase
      send_instr(cmd, 5'($urandom), a, b, $urandom);
    end
    idle_sender();
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    repeat (80) send_instr(rva_pkg::CMD_ADD + 10'($urandom_range(0, 15)), 5'($urandom),
                           $urandom, $urandom, $urandom, 1'b0);
    idle_sender();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(900);
    test_backpressure();
    test_random(950);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("rv32im_register_alu_core verification clean");
    end else begin
      $display("rv32im_register_alu_core verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/rva_pkg.sv
hdl/rva_front.sv
hdl/rva_div_cell.sv
hdl/rv32im_register_alu_core.sv
tb/sv/rv32im_register_alu_core_tb.sv
